// File: sv/svc_pkg.sv
`timescale 1ns / 1ps
package svc_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAM_X       = 3'd0,
    REG_CAM_Y       = 3'd1,
    REG_VIEW_WIDTH  = 3'd2,
    REG_VIEW_HEIGHT = 3'd3,
    REG_ZOOM_X      = 3'd4,
    REG_ZOOM_Y      = 3'd5
  } cfg_reg_t;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0: r = 34'sd536870912;
        5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;
        5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;
        5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;
        5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;
        5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;
        5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;
        5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;
        5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;
        5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;
        5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;
        5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;
        5'd23: r = 34'sd81;
        5'd24: r = 34'sd41;
        5'd25: r = 34'sd20;
        5'd26: r = 34'sd10;
        5'd27: r = 34'sd5;
        5'd28: r = 34'sd3;
        5'd29: r = 34'sd1;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction
endpackage

// File: sv/svc_cordic.sv
`timescale 1ns / 1ps
// one rotation step per stage, stall holds every stage
module svc_cordic #(
  parameter int ANGLE_BITS = svc_pkg::ANGLE_BITS
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [ANGLE_BITS-1:0] ang,
  output logic signed [17:0]   cos_q,
  output logic signed [17:0]   sin_q
);
  localparam int N = svc_pkg::CORDIC_STEPS;
  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic               flip_r [0:N];
  logic [31:0] t0, t1;
  logic        fl0;

  always_comb begin
    t0 = {ang, {(32-ANGLE_BITS){1'b0}}};
    fl0 = (t0 - 32'h4000_0000) < 32'h8000_0000;
    t1 = fl0 ? t0 + 32'h8000_0000 : t0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= svc_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= {{2{t1[31]}}, t1};
      flip_r[0] <= fl0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_step
      logic signed [33:0] xs, ys, atn;
      assign xs = x_r[g] >>> g;
      assign ys = y_r[g] >>> g;
      assign atn = svc_pkg::atan_turn(5'(g));
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!z_r[g][33]) begin
            x_r[g+1] <= x_r[g] - ys;
            y_r[g+1] <= y_r[g] + xs;
            z_r[g+1] <= z_r[g] - atn;
          end else begin
            x_r[g+1] <= x_r[g] + ys;
            y_r[g+1] <= y_r[g] - xs;
            z_r[g+1] <= z_r[g] + atn;
          end
          flip_r[g+1] <= flip_r[g];
        end
      end
    end
  endgenerate

  logic signed [33:0] xf, yf;
  always_comb begin
    xf = flip_r[N] ? -x_r[N] : x_r[N];
    yf = flip_r[N] ? -y_r[N] : y_r[N];
    cos_q = 18'(xf >>> 14);
    sin_q = 18'(yf >>> 14);
  end
endmodule

// File: sv/svc_delay.sv
`timescale 1ns / 1ps
module svc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] s_r [0:D-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0] <= d;
      for (int i = 1; i < D; i++) s_r[i] <= s_r[i-1];
    end
  end
  assign q = s_r[D-1];
endmodule

// File: sv/svc_box.sv
`timescale 1ns / 1ps
// sprite box and overlap test, after sine/cosine are known
module svc_box #(
  parameter int CB = svc_pkg::COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  vin,
  input  logic                  rot,
  input  logic signed [17:0]    c,
  input  logic signed [17:0]    s,
  input  logic signed [CB-1:0]  px,
  input  logic signed [CB-1:0]  py,
  input  logic signed [15:0]    sx,
  input  logic signed [15:0]    sy,
  input  logic [CB-1:0]         w,
  input  logic [CB-1:0]         h,
  input  logic [15:0]           gx,
  input  logic [15:0]           gy,
  input  logic signed [CB+10:0] bl,
  input  logic signed [CB+10:0] br,
  input  logic signed [CB+10:0] bb,
  input  logic signed [CB+10:0] bt,
  output logic                  vout,
  output logic                  vis
);
  localparam int MW = 26;
  localparam int SW = CB + 9;
  localparam int CW = CB + 3;
  localparam int EW = CB + 32;
  typedef logic signed [MW-1:0] mv_t;
  typedef logic signed [SW-1:0] sv_t;
  typedef logic signed [CW-1:0] cv_t;
  typedef logic signed [EW-1:0] ev_t;

  // stage a: matrix entries, scaled sizes, box centre
  logic v1_r, rot1_r;
  mv_t m0_r, m1_r, m3_r, m4_r;
  sv_t sw_r, sh_r;
  cv_t cx_r, cy_r;
  logic signed [CB-1:0] px1_r, py1_r;
  logic [CB-1:0] w1_r, h1_r;
  logic [15:0] gx1_r, gy1_r;
  logic signed [CB+10:0] bl1_r, br1_r, bb1_r, bt1_r;

  logic signed [33:0] cm0, cm1, cm3, cm4;
  logic signed [CB+16:0] swp, shp;
  logic signed [17:0] gxo, gyo;
  logic signed [CB+17:0] cxp, cyp;
  always_comb begin
    cm0 = c * sx;
    cm1 = s * sx;
    cm3 = -s * sy;
    cm4 = c * sy;
    swp = $signed({1'b0, w}) * sx;
    shp = $signed({1'b0, h}) * sy;
    gxo = 18'sd16384 - $signed({2'b0, gx});
    gyo = 18'sd16384 - $signed({2'b0, gy});
    cxp = $signed({1'b0, w}) * gxo;
    cyp = $signed({1'b0, h}) * gyo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= vin;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rot1_r <= rot;
      m0_r <= cm0[MW+7:8];
      m1_r <= cm1[MW+7:8];
      m3_r <= cm3[MW+7:8];
      m4_r <= cm4[MW+7:8];
      sw_r <= swp[CB+16:8];
      sh_r <= shp[CB+16:8];
      cx_r <= cxp[CB+17:15];
      cy_r <= cyp[CB+17:15];
      px1_r <= px; py1_r <= py; w1_r <= w; h1_r <= h; gx1_r <= gx; gy1_r <= gy;
      bl1_r <= bl; br1_r <= br; bb1_r <= bb; bt1_r <= bt;
    end
  end

  // stage b: products
  logic v2_r, rot2_r;
  ev_t p0_r, p1_r, p2_r, p3_r, e0_r, e1_r, e2_r, e3_r, ax_r, ay_r;
  sv_t sw2_r, sh2_r;
  logic signed [CB-1:0] px2_r, py2_r;
  logic signed [CB+10:0] bl2_r, br2_r, bb2_r, bt2_r;
  mv_t a0, a1, a3, a4;
  always_comb begin
    a0 = m0_r[MW-1] ? -m0_r : m0_r;
    a1 = m1_r[MW-1] ? -m1_r : m1_r;
    a3 = m3_r[MW-1] ? -m3_r : m3_r;
    a4 = m4_r[MW-1] ? -m4_r : m4_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rot2_r <= rot1_r;
      p0_r <= m0_r * cx_r; p1_r <= m3_r * cy_r;
      p2_r <= m1_r * cx_r; p3_r <= m4_r * cy_r;
      e0_r <= a0 * $signed({1'b0, w1_r}); e1_r <= a3 * $signed({1'b0, h1_r});
      e2_r <= a1 * $signed({1'b0, w1_r}); e3_r <= a4 * $signed({1'b0, h1_r});
      ax_r <= (sw_r * $signed({1'b0, gx1_r})) >>> 15;
      ay_r <= (sh_r * $signed({1'b0, gy1_r})) >>> 15;
      sw2_r <= sw_r; sh2_r <= sh_r; px2_r <= px1_r; py2_r <= py1_r;
      bl2_r <= bl1_r; br2_r <= br1_r; bb2_r <= bb1_r; bt2_r <= bt1_r;
    end
  end

  // stage c: box edges at doubled scale
  logic v3_r;
  ev_t al_r, ar_r, ab_r, at_r;
  logic signed [CB+10:0] bl3_r, br3_r, bb3_r, bt3_r;
  ev_t x1, y1, dx, dy, l0, b0;
  always_comb begin
    x1 = ((p0_r + p1_r) >>> 16) + EW'(px2_r);
    y1 = ((p2_r + p3_r) >>> 16) + EW'(py2_r);
    dx = (e0_r + e1_r) >>> 16;
    dy = (e2_r + e3_r) >>> 16;
    l0 = 2 * (EW'(px2_r) - ax_r);
    b0 = 2 * (EW'(py2_r) - ay_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (rot2_r) begin
        al_r <= 2 * x1 - dx; ar_r <= 2 * x1 + dx;
        ab_r <= 2 * y1 - dy; at_r <= 2 * y1 + dy;
      end else begin
        al_r <= l0; ar_r <= l0 + 2 * EW'(sw2_r);
        ab_r <= b0; at_r <= b0 + 2 * EW'(sh2_r);
      end
      bl3_r <= bl2_r; br3_r <= br2_r; bb3_r <= bb2_r; bt3_r <= bt2_r;
    end
  end

  assign vout = v3_r;
  assign vis = (al_r < EW'(br3_r)) && (EW'(bl3_r) < ar_r)
            && (ab_r < EW'(bt3_r)) && (EW'(bb3_r) < at_r);
endmodule

// File: sv/sprite_view_cull.sv
`timescale 1ns / 1ps
// Streaming 2D sprite culler: while out_stall is low, one sprite is accepted every
// cycle and its visible flag passes one input register, 30 CORDIC stages for sine
// and cosine, three box stages and one output register; the CORDIC pipeline length
// sets the latency. out_stall freezes the whole pipeline; in_stall follows out_stall.
// Camera registers: written through cfg_we/cfg_idx/cfg_data while idle (user's duty).
module sprite_view_cull #(
  parameter int ANGLE_BITS = svc_pkg::ANGLE_BITS,
  parameter int COORD_BITS = svc_pkg::COORD_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [svc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic [ANGLE_BITS-1:0] in_angle,
  input  logic signed [15:0] in_obj_scale_x,
  input  logic signed [15:0] in_obj_scale_y,
  input  logic [COORD_BITS-1:0] in_obj_width,
  input  logic [COORD_BITS-1:0] in_obj_height,
  input  logic [15:0] in_anchor_x,
  input  logic [15:0] in_anchor_y,
  output logic out_valid,
  input  logic out_stall,
  output logic out_visible
);
  localparam int CB = COORD_BITS;
  localparam int DL = svc_pkg::CORDIC_STEPS + 1;
  localparam int PW = 2 * CB + 2 * CB + 16 + 16 + 16 + 16 + 1 + 4 * (CB + 11);

  logic signed [CB-1:0] cam_x_r, cam_y_r;
  logic [CB-1:0] vw_r, vh_r;
  logic [15:0] zx_r, zy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0; cam_y_r <= '0; vw_r <= '0; vh_r <= '0;
      zx_r <= 16'd256; zy_r <= 16'd256;
    end else if (cfg_we) begin
      case (svc_pkg::cfg_reg_t'(cfg_idx))
        svc_pkg::REG_CAM_X: cam_x_r <= cfg_data;
        svc_pkg::REG_CAM_Y: cam_y_r <= cfg_data;
        svc_pkg::REG_VIEW_WIDTH: vw_r <= cfg_data;
        svc_pkg::REG_VIEW_HEIGHT: vh_r <= cfg_data;
        svc_pkg::REG_ZOOM_X: zx_r <= cfg_data[15:0];
        svc_pkg::REG_ZOOM_Y: zy_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // camera edges, doubled scale
  logic [CB+15:0] vwp, vhp;
  logic signed [CB+10:0] cx2, cy2, vws, vhs;
  logic signed [CB+10:0] bl, br, bb, bt;
  always_comb begin
    vwp = vw_r * zx_r;
    vhp = vh_r * zy_r;
    vws = $signed({3'b0, vwp[CB+15:8]});
    vhs = $signed({3'b0, vhp[CB+15:8]});
    cx2 = {{10{cam_x_r[CB-1]}}, cam_x_r, 1'b0};
    cy2 = {{10{cam_y_r[CB-1]}}, cam_y_r, 1'b0};
    bl = cx2 - vws;
    br = cx2 + vws;
    bb = cy2 - vhs;
    bt = cy2 + vhs;
  end

  logic adv;
  assign adv = !out_stall;
  assign in_stall = out_stall;

  logic [DL-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[DL-2:0], in_valid};
  end

  logic [PW-1:0] pin, pout;
  assign pin = {in_pos_x, in_pos_y, in_obj_width, in_obj_height, in_obj_scale_x,
                in_obj_scale_y, in_anchor_x, in_anchor_y, (in_angle != '0), bl, br, bb, bt};

  svc_delay #(.W(PW), .D(DL)) u_dly (.clk(clk), .adv(adv), .d(pin), .q(pout));

  logic signed [17:0] c, s;
  svc_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .adv(adv), .ang(in_angle), .cos_q(c), .sin_q(s));

  logic signed [CB-1:0] px, py;
  logic [CB-1:0] w, h;
  logic signed [15:0] sx, sy;
  logic [15:0] gx, gy;
  logic rot;
  logic signed [CB+10:0] dbl, dbr, dbb, dbt;
  assign {px, py, w, h, sx, sy, gx, gy, rot, dbl, dbr, dbb, dbt} = pout;

  logic bv, bvis;
  svc_box #(.CB(CB)) u_box (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vin(v_r[DL-1]), .rot(rot), .c(c), .s(s),
    .px(px), .py(py), .sx(sx), .sy(sy), .w(w), .h(h), .gx(gx), .gy(gy),
    .bl(dbl), .br(dbr), .bb(dbb), .bt(dbt), .vout(bv), .vis(bvis));

  logic ov_r, vis_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= bv;
  end
  always_ff @(posedge clk) begin
    if (adv) vis_r <= bvis;
  end
  assign out_valid = ov_r;
  assign out_visible = vis_r;
endmodule
